[hdl/s256d_pkg.sv]
// ----------------------------------------------------------------------------
// s256d_pkg
// Types, constants and the round function of the double SHA-256 nonce hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package s256d_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_AB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_CD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_EF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIDSTATE_GH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_ROOT_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BITS      = 3'd5;

  localparam logic [31:0] PAD_WORD    = 32'h80000000;
  localparam logic [31:0] LEN_FIRST   = 32'h00000280;
  localparam logic [31:0] LEN_SECOND  = 32'h00000100;

  typedef logic [7:0][31:0]  hstate_t;
  typedef logic [15:0][31:0] window_t;

  typedef struct packed {
    hstate_t st;
    window_t win;
  } round_out_t;

  localparam hstate_t STD_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] ROUND_K = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  function automatic hstate_t add_state(input hstate_t a, input hstate_t b);
    hstate_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = a[i] + b[i];
    end
    return r;
  endfunction

  // The window holds W[t] .. W[t+15]; word 0 is used by this round.
  function automatic round_out_t sha_round(input hstate_t st, input window_t win,
                                           input logic [31:0] k);
    round_out_t  r;
    logic [31:0] t1, t2, s0, s1, wn;
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    wn = win[0] + s0 + win[9] + s1;
    t1 = st[7] + (rotr(st[4], 6) ^ rotr(st[4], 11) ^ rotr(st[4], 25)) +
         ((st[4] & st[5]) ^ (~st[4] & st[6])) + k + win[0];
    t2 = (rotr(st[0], 2) ^ rotr(st[0], 13) ^ rotr(st[0], 22)) +
         ((st[0] & st[1]) ^ (st[0] & st[2]) ^ (st[1] & st[2]));
    r.st[7] = st[6];
    r.st[6] = st[5];
    r.st[5] = st[4];
    r.st[4] = st[3] + t1;
    r.st[3] = st[2];
    r.st[2] = st[1];
    r.st[1] = st[0];
    r.st[0] = t1 + t2;
    for (int i = 0; i < 15; i++) begin
      r.win[i] = win[i+1];
    end
    r.win[15] = wn;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/s256d_if.sv]
// ----------------------------------------------------------------------------
// s256d channel interfaces
// Nonce input, digest output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface s256d_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] nonce;
  modport source (output valid, output nonce, input ready);
  modport sink   (input valid, input nonce, output ready);
endinterface

interface s256d_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_ab;
  logic [63:0] digest_cd;
  logic [63:0] digest_ef;
  logic [63:0] digest_gh;
  logic        share_candidate;
  modport source (output valid, output digest_ab, output digest_cd, output digest_ef,
                  output digest_gh, output share_candidate, input ready);
  modport sink   (input valid, input digest_ab, input digest_cd, input digest_ef,
                  input digest_gh, input share_candidate, output ready);
endinterface

interface s256d_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [s256d_pkg::CFG_IDX_W-1:0]    index;
  logic [63:0]                        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/sha256d_header_nonce_hasher.sv]
// ----------------------------------------------------------------------------
// sha256d_header_nonce_hasher
// Double SHA-256 of a block header finished from a midstate, one nonce per item.
// ----------------------------------------------------------------------------
// The user writes the midstate and the first three tail words over cfg_chan
// only while the block is idle; the block does not enforce it. cfg_chan is
// always ready. Each nonce item on in_chan gives one item on out_chan with the
// final digest words and the candidate flag. The datapath has one register
// stage per SHA-256 round: an entry stage, 64 rounds, a stage that adds the
// midstate back, 64 rounds and the output register.
// One item is accepted per cycle, one nonce per clock, unless out_chan stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_chan.ready is low; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256d_header_nonce_hasher (
  input  wire logic  clk,
  input  wire logic  rst_n,
  s256d_in_if.sink   in_chan,
  s256d_out_if.source out_chan,
  s256d_cfg_if.sink  cfg_chan
);

  localparam int unsigned NST = 2 * s256d_pkg::NUM_ROUNDS + 2;

  logic [63:0] midstate_ab_r, midstate_cd_r, midstate_ef_r, midstate_gh_r;
  logic [63:0] tail_root_time_r;
  logic [31:0] tail_bits_r;

  s256d_pkg::hstate_t st_r  [NST];
  s256d_pkg::window_t win_r [NST];
  logic [NST-1:0]     vld_r;

  s256d_pkg::hstate_t mid;
  s256d_pkg::hstate_t out_st_r;
  logic               out_valid_r;
  logic               adv;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  assign mid = {midstate_gh_r[31:0], midstate_gh_r[63:32], midstate_ef_r[31:0],
                midstate_ef_r[63:32], midstate_cd_r[31:0], midstate_cd_r[63:32],
                midstate_ab_r[31:0], midstate_ab_r[63:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      midstate_ab_r    <= '0;
      midstate_cd_r    <= '0;
      midstate_ef_r    <= '0;
      midstate_gh_r    <= '0;
      tail_root_time_r <= '0;
      tail_bits_r      <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        s256d_pkg::REG_MIDSTATE_AB:    midstate_ab_r    <= cfg_chan.data;
        s256d_pkg::REG_MIDSTATE_CD:    midstate_cd_r    <= cfg_chan.data;
        s256d_pkg::REG_MIDSTATE_EF:    midstate_ef_r    <= cfg_chan.data;
        s256d_pkg::REG_MIDSTATE_GH:    midstate_gh_r    <= cfg_chan.data;
        s256d_pkg::REG_TAIL_ROOT_TIME: tail_root_time_r <= cfg_chan.data;
        s256d_pkg::REG_TAIL_BITS:      tail_bits_r      <= cfg_chan.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_chan.valid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    s256d_pkg::round_out_t ro_a, ro_b;
    if (adv) begin
      st_r[0]  <= mid;
      win_r[0] <= {s256d_pkg::LEN_FIRST, 320'd0, s256d_pkg::PAD_WORD,
                   in_chan.nonce[7:0], in_chan.nonce[15:8],
                   in_chan.nonce[23:16], in_chan.nonce[31:24],
                   tail_bits_r, tail_root_time_r[31:0], tail_root_time_r[63:32]};
      st_r[s256d_pkg::NUM_ROUNDS+1]  <= s256d_pkg::STD_IV;
      win_r[s256d_pkg::NUM_ROUNDS+1] <= {s256d_pkg::LEN_SECOND, 192'd0,
                                         s256d_pkg::PAD_WORD,
                                         s256d_pkg::add_state(mid,
                                           st_r[s256d_pkg::NUM_ROUNDS])};
      for (int r = 0; r < s256d_pkg::NUM_ROUNDS; r++) begin
        ro_a = s256d_pkg::sha_round(st_r[r], win_r[r], s256d_pkg::ROUND_K[r]);
        ro_b = s256d_pkg::sha_round(st_r[r+s256d_pkg::NUM_ROUNDS+1],
                                    win_r[r+s256d_pkg::NUM_ROUNDS+1],
                                    s256d_pkg::ROUND_K[r]);
        st_r[r+1]                       <= ro_a.st;
        win_r[r+1]                      <= ro_a.win;
        st_r[r+s256d_pkg::NUM_ROUNDS+2]  <= ro_b.st;
        win_r[r+s256d_pkg::NUM_ROUNDS+2] <= ro_b.win;
      end
      out_st_r <= s256d_pkg::add_state(s256d_pkg::STD_IV, st_r[NST-1]);
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.digest_ab       = {out_st_r[0], out_st_r[1]};
  assign out_chan.digest_cd       = {out_st_r[2], out_st_r[3]};
  assign out_chan.digest_ef       = {out_st_r[4], out_st_r[5]};
  assign out_chan.digest_gh       = {out_st_r[6], out_st_r[7]};
  assign out_chan.share_candidate = (out_st_r[7][15:0] == 16'd0);

endmodule
`default_nettype wire
